[rtl/tas_pkg.sv]
// Shared constants, types and codes of the threshold assignment solver.
// No dependencies; every other file of the block but tas_ram refers to it by scoped names.
`timescale 1ns / 1ps
package tas_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 5;
  localparam int IDX_W  = 4;
  localparam int TOT_W  = 5;
  localparam int CFG_W  = 2;

  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int LW    = $clog2(CELLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int GW    = $clog2(MAX_COLS + 2);
  localparam int POT_W = $clog2(MAX_ROWS + MAX_COLS + 2) + 2;

  localparam logic [CFG_W-1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [CFG_W-1:0] CFG_COL_COUNT = 2'd1;
  localparam logic [CFG_W-1:0] CFG_THRESHOLD = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_INIT,
    ST_PHASE,
    ST_ITER,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_SCAN_END,
    ST_UPDATE,
    ST_AUGMENT,
    ST_NEXT_ROW,
    ST_MATCH,
    ST_MATCH_EV,
    ST_EMIT
  } state_e;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_ERR_OUT,
    CMD_INIT,
    CMD_PHASE,
    CMD_ITER,
    CMD_SCAN_RD,
    CMD_SCAN_EV,
    CMD_UPD_INIT,
    CMD_UPDATE,
    CMD_AUG_INIT,
    CMD_AUGMENT,
    CMD_NEXT_ROW,
    CMD_MX_SKIP,
    CMD_MX_RD,
    CMD_MX_EV,
    CMD_EMIT_INIT,
    CMD_EMIT
  } cmd_e;

  typedef struct packed {
    logic slot_free;
    logic last_elem;
    logic too_many;
    logic scan_done;
    logic found;
    logic upd_last;
    logic stop_search;
    logic aug_done;
    logic last_row;
    logic mx_hit;
  } sts_t;

endpackage

[rtl/tas_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the threshold cost bits of the solver.
`timescale 1ns / 1ps
module tas_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tas_ctrl.sv]
// Sequencer of the solver: state register and command decode.
// Depends on tas_pkg for the state, command and status types.
`timescale 1ns / 1ps
module tas_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  tas_pkg::sts_t sts_i,
  output tas_pkg::cmd_e cmd_o,
  output logic          in_ready_o
);

  tas_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tas_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = tas_pkg::CMD_NOP;
    in_ready_o = 1'b0;
    unique case (state_q)
      tas_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o = tas_pkg::CMD_LOAD;
          if (sts_i.last_elem) begin
            state_d = sts_i.too_many ? tas_pkg::ST_ERR : tas_pkg::ST_INIT;
          end
        end
      end
      tas_pkg::ST_ERR: begin
        if (sts_i.slot_free) begin
          cmd_o   = tas_pkg::CMD_ERR_OUT;
          state_d = tas_pkg::ST_IDLE;
        end
      end
      tas_pkg::ST_INIT: begin
        cmd_o   = tas_pkg::CMD_INIT;
        state_d = tas_pkg::ST_PHASE;
      end
      tas_pkg::ST_PHASE: begin
        cmd_o   = tas_pkg::CMD_PHASE;
        state_d = tas_pkg::ST_ITER;
      end
      tas_pkg::ST_ITER: begin
        cmd_o   = tas_pkg::CMD_ITER;
        state_d = tas_pkg::ST_SCAN_RD;
      end
      tas_pkg::ST_SCAN_RD: begin
        if (sts_i.scan_done) begin
          state_d = tas_pkg::ST_SCAN_END;
        end else begin
          cmd_o   = tas_pkg::CMD_SCAN_RD;
          state_d = tas_pkg::ST_SCAN_EV;
        end
      end
      tas_pkg::ST_SCAN_EV: begin
        cmd_o   = tas_pkg::CMD_SCAN_EV;
        state_d = tas_pkg::ST_SCAN_RD;
      end
      tas_pkg::ST_SCAN_END: begin
        if (sts_i.found) begin
          cmd_o   = tas_pkg::CMD_UPD_INIT;
          state_d = tas_pkg::ST_UPDATE;
        end else begin
          cmd_o   = tas_pkg::CMD_AUG_INIT;
          state_d = tas_pkg::ST_AUGMENT;
        end
      end
      tas_pkg::ST_UPDATE: begin
        cmd_o = tas_pkg::CMD_UPDATE;
        if (sts_i.upd_last) begin
          state_d = sts_i.stop_search ? tas_pkg::ST_AUGMENT : tas_pkg::ST_ITER;
        end
      end
      tas_pkg::ST_AUGMENT: begin
        if (sts_i.aug_done) begin
          state_d = tas_pkg::ST_NEXT_ROW;
        end else begin
          cmd_o = tas_pkg::CMD_AUGMENT;
        end
      end
      tas_pkg::ST_NEXT_ROW: begin
        cmd_o   = tas_pkg::CMD_NEXT_ROW;
        state_d = sts_i.last_row ? tas_pkg::ST_MATCH : tas_pkg::ST_PHASE;
      end
      tas_pkg::ST_MATCH: begin
        if (sts_i.scan_done) begin
          cmd_o   = tas_pkg::CMD_EMIT_INIT;
          state_d = tas_pkg::ST_EMIT;
        end else if (sts_i.mx_hit) begin
          cmd_o   = tas_pkg::CMD_MX_RD;
          state_d = tas_pkg::ST_MATCH_EV;
        end else begin
          cmd_o = tas_pkg::CMD_MX_SKIP;
        end
      end
      tas_pkg::ST_MATCH_EV: begin
        cmd_o   = tas_pkg::CMD_MX_EV;
        state_d = tas_pkg::ST_MATCH;
      end
      tas_pkg::ST_EMIT: begin
        if (sts_i.slot_free) begin
          cmd_o = tas_pkg::CMD_EMIT;
          if (sts_i.last_row) begin
            state_d = tas_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = tas_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/tas_dp.sv]
// Datapath of the solver: configuration, cost bit store, potentials, slack,
// matching and the result register. Depends on tas_pkg and tas_ram.
`timescale 1ns / 1ps
module tas_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tas_pkg::cmd_e                     cmd_i,
  input  logic                              cfg_we_i,
  input  logic [tas_pkg::CFG_W-1:0]         cfg_index_i,
  input  logic [tas_pkg::DATA_W-1:0]        cfg_wdata_i,
  input  logic signed [tas_pkg::DATA_W-1:0] element_value_i,
  input  logic                              last_element_i,
  output tas_pkg::sts_t                     sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tas_pkg::IDX_W-1:0]         row_index_o,
  output logic [tas_pkg::IDX_W-1:0]         col_index_o,
  output logic                              edge_bad_o,
  output logic [tas_pkg::TOT_W-1:0]         total_bad_o,
  output logic                              status_o,
  output logic                              last_result_o
);

  localparam int MR = tas_pkg::MAX_ROWS;
  localparam int MC = tas_pkg::MAX_COLS;
  localparam int RW = tas_pkg::RW;
  localparam int CW = tas_pkg::CW;
  localparam int GW = tas_pkg::GW;
  localparam int AW = tas_pkg::AW;
  localparam int LW = tas_pkg::LW;
  localparam int PW = tas_pkg::POT_W;

  logic [tas_pkg::CNT_W-1:0]         row_cnt_q, col_cnt_q;
  logic signed [tas_pkg::DATA_W-1:0] thr_q;
  logic [LW-1:0]                     load_cnt_q;

  logic signed [PW-1:0] rp_q    [MR+1];
  logic signed [PW-1:0] cp_q    [MC+1];
  logic [RW-1:0]        owner_q [MC+1];
  logic [CW-1:0]        back_q  [MC+1];
  logic signed [PW-1:0] slack_q [MC+1];
  logic                 slinf_q [MC+1];
  logic                 vis_q   [MC+1];
  logic [CW-1:0]        match_q [MR+1];
  logic                 bad_q   [MR+1];

  logic [RW-1:0]        r_q, rowh_q, total_q;
  logic [GW-1:0]        c_q, g_q;
  logic [CW-1:0]        cur_q, nxt_q;
  logic signed [PW-1:0] u_q, step_q;
  logic                 found_q;

  logic                      out_valid_q;
  logic [tas_pkg::IDX_W-1:0] o_row_q, o_col_q;
  logic                      o_bad_q, o_status_q, o_last_q;
  logic [tas_pkg::TOT_W-1:0] o_total_q;

  logic [RW-1:0]        rows_c, owner_c, own_cur, sel_row;
  logic [CW-1:0]        cols_c, ci;
  logic [GW-1:0]        cols_g;
  logic                 bit_c, less_c, better_c, load_ok;
  logic signed [PW-1:0] reduced_c, newsl_c;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_raddr;

  assign rows_c = (row_cnt_q == '0) ? RW'(1) :
                  ((int'(row_cnt_q) > MR) ? RW'(MR) : RW'(row_cnt_q));
  assign cols_c = (col_cnt_q == '0) ? CW'(1) :
                  ((int'(col_cnt_q) > MC) ? CW'(MC) : CW'(col_cnt_q));
  assign cols_g = GW'(cols_c);

  assign ci      = c_q[CW-1:0];
  assign owner_c = owner_q[ci];
  assign own_cur = owner_q[cur_q];
  assign load_ok = (int'(load_cnt_q) < tas_pkg::CELLS);

  assign sel_row   = (cmd_i == tas_pkg::CMD_MX_RD) ? owner_c : rowh_q;
  assign ram_raddr = AW'(AW'(sel_row - RW'(1)) * AW'(cols_c)) + AW'(ci - CW'(1));
  assign ram_we    = (cmd_i == tas_pkg::CMD_LOAD) && load_ok;
  assign ram_re    = (cmd_i == tas_pkg::CMD_SCAN_RD) || (cmd_i == tas_pkg::CMD_MX_RD);

  tas_ram #(
    .WIDTH(1),
    .DEPTH(tas_pkg::CELLS)
  ) u_cost_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(load_cnt_q[AW-1:0]),
    .wdata_i(element_value_i > thr_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(bit_c)
  );

  assign reduced_c = $signed({{(PW-1){1'b0}}, bit_c}) - u_q - cp_q[ci];
  assign less_c    = slinf_q[ci] || (reduced_c < slack_q[ci]);
  assign newsl_c   = less_c ? reduced_c : slack_q[ci];
  assign better_c  = !found_q || (newsl_c < step_q);

  always_comb begin
    sts_o             = '0;
    sts_o.slot_free   = !out_valid_q || out_ready_i;
    sts_o.last_elem   = last_element_i;
    sts_o.too_many    = (int'(rows_c) > int'(cols_c));
    sts_o.scan_done   = (c_q > cols_g);
    sts_o.found       = found_q;
    sts_o.upd_last    = (c_q == cols_g);
    sts_o.stop_search = (owner_q[nxt_q] == '0) || (g_q == cols_g);
    sts_o.aug_done    = (cur_q == '0) || (g_q > cols_g);
    sts_o.last_row    = (r_q == rows_c);
    sts_o.mx_hit      = (owner_c != '0) && (owner_c <= rows_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q   <= tas_pkg::CNT_W'(1);
      col_cnt_q   <= tas_pkg::CNT_W'(1);
      thr_q       <= '0;
      load_cnt_q  <= '0;
      r_q         <= '0;
      c_q         <= '0;
      g_q         <= '0;
      cur_q       <= '0;
      nxt_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          tas_pkg::CFG_ROW_COUNT: row_cnt_q <= cfg_wdata_i[tas_pkg::CNT_W-1:0];
          tas_pkg::CFG_COL_COUNT: col_cnt_q <= cfg_wdata_i[tas_pkg::CNT_W-1:0];
          tas_pkg::CFG_THRESHOLD: thr_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if ((cmd_i == tas_pkg::CMD_EMIT) || (cmd_i == tas_pkg::CMD_ERR_OUT)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i)
        tas_pkg::CMD_LOAD: begin
          if (last_element_i) begin
            load_cnt_q <= '0;
          end else if (load_ok) begin
            load_cnt_q <= load_cnt_q + LW'(1);
          end
        end
        tas_pkg::CMD_INIT: r_q <= RW'(1);
        tas_pkg::CMD_PHASE: begin
          cur_q <= '0;
          g_q   <= '0;
        end
        tas_pkg::CMD_ITER: begin
          found_q <= 1'b0;
          c_q     <= GW'(1);
        end
        tas_pkg::CMD_SCAN_EV: begin
          if (!vis_q[ci] && better_c) begin
            nxt_q   <= ci;
            found_q <= 1'b1;
          end
          c_q <= c_q + GW'(1);
        end
        tas_pkg::CMD_UPD_INIT: c_q <= '0;
        tas_pkg::CMD_UPDATE: begin
          if (c_q == cols_g) begin
            cur_q <= nxt_q;
            g_q   <= sts_o.stop_search ? '0 : g_q + GW'(1);
          end else begin
            c_q <= c_q + GW'(1);
          end
        end
        tas_pkg::CMD_AUG_INIT: g_q <= '0;
        tas_pkg::CMD_AUGMENT: begin
          cur_q <= back_q[cur_q];
          g_q   <= g_q + GW'(1);
        end
        tas_pkg::CMD_NEXT_ROW: begin
          if (r_q == rows_c) begin
            c_q <= GW'(1);
          end else begin
            r_q <= r_q + RW'(1);
          end
        end
        tas_pkg::CMD_MX_SKIP,
        tas_pkg::CMD_MX_EV: c_q <= c_q + GW'(1);
        tas_pkg::CMD_EMIT_INIT: r_q <= RW'(1);
        tas_pkg::CMD_EMIT: r_q <= r_q + RW'(1);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      tas_pkg::CMD_INIT: begin
        for (int i = 0; i <= MR; i++) begin
          rp_q[i]    <= '0;
          match_q[i] <= '0;
          bad_q[i]   <= 1'b0;
        end
        for (int i = 0; i <= MC; i++) begin
          cp_q[i]    <= '0;
          owner_q[i] <= '0;
          back_q[i]  <= '0;
        end
      end
      tas_pkg::CMD_PHASE: begin
        owner_q[0] <= r_q;
        for (int i = 0; i <= MC; i++) begin
          slinf_q[i] <= 1'b1;
          vis_q[i]   <= 1'b0;
        end
      end
      tas_pkg::CMD_ITER: begin
        vis_q[cur_q] <= 1'b1;
        rowh_q       <= own_cur;
        u_q          <= rp_q[own_cur];
      end
      tas_pkg::CMD_SCAN_EV: begin
        if (!vis_q[ci]) begin
          if (less_c) begin
            slack_q[ci] <= reduced_c;
            slinf_q[ci] <= 1'b0;
            back_q[ci]  <= cur_q;
          end
          if (better_c) begin
            step_q <= newsl_c;
          end
        end
      end
      tas_pkg::CMD_UPDATE: begin
        if (vis_q[ci]) begin
          rp_q[owner_c] <= rp_q[owner_c] + step_q;
          cp_q[ci]      <= cp_q[ci] - step_q;
        end else begin
          slack_q[ci] <= slack_q[ci] - step_q;
        end
      end
      tas_pkg::CMD_AUGMENT: owner_q[cur_q] <= owner_q[back_q[cur_q]];
      tas_pkg::CMD_NEXT_ROW: total_q <= '0;
      tas_pkg::CMD_MX_EV: begin
        match_q[owner_c] <= ci;
        bad_q[owner_c]   <= bit_c;
        total_q          <= total_q + RW'(bit_c);
      end
      tas_pkg::CMD_EMIT: begin
        o_row_q    <= tas_pkg::IDX_W'(r_q - RW'(1));
        o_col_q    <= (match_q[r_q] == '0) ? '0 :
                      tas_pkg::IDX_W'(match_q[r_q] - CW'(1));
        o_bad_q    <= bad_q[r_q];
        o_total_q  <= tas_pkg::TOT_W'(total_q);
        o_status_q <= 1'b0;
        o_last_q   <= (r_q == rows_c);
      end
      tas_pkg::CMD_ERR_OUT: begin
        o_row_q    <= '0;
        o_col_q    <= '0;
        o_bad_q    <= 1'b0;
        o_total_q  <= '0;
        o_status_q <= 1'b1;
        o_last_q   <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign row_index_o   = o_row_q;
  assign col_index_o   = o_col_q;
  assign edge_bad_o    = o_bad_q;
  assign total_bad_o   = o_total_q;
  assign status_o      = o_status_q;
  assign last_result_o = o_last_q;

endmodule

[rtl/threshold_assignment_solver_unit.sv]
// Top level of the threshold assignment solver: sequencer plus datapath.
// Depends on tas_pkg, tas_ctrl, tas_dp and tas_ram.
//
// Matrix elements enter row-major on the input channel, one beat per cycle;
// each is reduced to a single cost bit (element above threshold) in a bit
// store. A beat with last_element set starts the solve, and input is held off
// until the last result has been loaded into the output register.
// The solve runs the rectangular Hungarian method one column per step: per
// row, up to cols+1 search rounds, each a serial column scan and a column
// update pass, then an augment along the back pointers; a final matching
// sweep over the columns collects the result. The single bit store read
// port and the serial column scan set the run time. One result beat per
// row follows, at most one per cycle while the receiver takes them; if
// row_count exceeds col_count (each clamped to 1..16), a single error beat
// with status set is sent instead. A stalled receiver holds the current
// result in the output register and halts the emission; the next run's
// loading may begin as soon as the final result is in that register.
// Reset restores the configuration defaults and an empty load position;
// the bit store itself is not cleared.
`timescale 1ns / 1ps
module threshold_assignment_solver_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tas_pkg::CFG_W-1:0]         cfg_index_i,
  input  logic [tas_pkg::DATA_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [tas_pkg::DATA_W-1:0] element_value_i,
  input  logic                              last_element_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tas_pkg::IDX_W-1:0]         row_index_o,
  output logic [tas_pkg::IDX_W-1:0]         col_index_o,
  output logic                              edge_bad_o,
  output logic [tas_pkg::TOT_W-1:0]         total_bad_o,
  output logic                              status_o,
  output logic                              last_result_o
);

  tas_pkg::cmd_e cmd;
  tas_pkg::sts_t sts;

  tas_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .in_ready_o(in_ready_o)
  );

  tas_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .element_value_i(element_value_i),
    .last_element_i (last_element_i),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .row_index_o    (row_index_o),
    .col_index_o    (col_index_o),
    .edge_bad_o     (edge_bad_o),
    .total_bad_o    (total_bad_o),
    .status_o       (status_o),
    .last_result_o  (last_result_o)
  );

  // An error beat is always the only beat of its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> last_result_o && (row_index_o == '0))
    else $error("error beat is not a lone final beat");

  // A bad matched edge cannot coexist with a zero total.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && edge_bad_o |-> (total_bad_o != '0) && !status_o)
    else $error("bad edge reported with zero total");

  // Input is closed during the solve that a final beat starts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_element_i |=> !in_ready_o)
    else $error("input accepted during solve");

endmodule
